/* hdl/tgr_pkg.sv */
// package: shared constants, codes and types of the text console glyph renderer
package tgr_pkg;

    localparam int GLYPH_HEIGHT     = 16;
    localparam int FONT_STORE_BYTES = 2048;
    localparam int FONT_AW          = $clog2(FONT_STORE_BYTES);
    localparam int GROW_W           = $clog2(GLYPH_HEIGHT);
    localparam int LINE_W           = 8 + GROW_W;
    localparam int GADDR_W          = 8 + GROW_W;
    localparam int PIX_W            = 24;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TEXT_COLUMNS = 2'd1;
    localparam logic [1:0] CFG_TEXT_ROWS    = 2'd2;

    localparam logic [12:0] RST_SCREEN_WIDTH = 13'd640;
    localparam logic [9:0]  RST_TEXT_COLUMNS = 10'd80;
    localparam logic [8:0]  RST_TEXT_ROWS    = 9'd30;

    localparam logic       CMD_PRINT   = 1'b0;
    localparam logic       CMD_LOAD    = 1'b1;
    localparam logic       KIND_GLYPH  = 1'b0;
    localparam logic       KIND_SCROLL = 1'b1;
    localparam logic [7:0] CODE_NULL     = 8'h00;
    localparam logic [7:0] CODE_NEWLINE  = 8'h0A;
    localparam logic [7:0] CODE_QUESTION = 8'h3F;

    typedef struct packed {
        logic       scroll;
        logic       glyph;
        logic [7:0] code;
        logic [9:0] column;
        logic [7:0] row;
    } t_desc;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic idle;
    } t_back_status;

endpackage

/* hdl/tgr_ram.sv */
// generic single write port ram with registered read
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tgr_queue.sv */
// descriptor queue between front and back
module tgr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tgr_pkg::t_desc      i_desc,
    input  logic                i_pop,
    output tgr_pkg::t_desc      o_desc,
    output tgr_pkg::t_q_status  o_status
);

    tgr_pkg::t_desc                r_mem [tgr_pkg::QUEUE_DEPTH];
    logic [tgr_pkg::QPTR_W-1:0]    r_wptr;
    logic [tgr_pkg::QPTR_W-1:0]    r_rptr;
    logic [tgr_pkg::QPTR_W:0]      r_count;
    logic [tgr_pkg::QPTR_W-1:0]    n_wptr;
    logic [tgr_pkg::QPTR_W-1:0]    n_rptr;
    logic [tgr_pkg::QPTR_W:0]      n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

    assign o_desc         = r_mem[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (tgr_pkg::QPTR_W+1)'(tgr_pkg::QUEUE_DEPTH));

endmodule

/* hdl/tgr_front.sv */
// front: accepts words, loads font bytes, moves the cursor, queues print work
module tgr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_char_code,
    input  logic [10:0]                  i_font_address,
    input  logic [7:0]                   i_font_byte,
    input  logic [9:0]                   i_text_columns,
    input  logic [8:0]                   i_text_rows,
    input  tgr_pkg::t_q_status           i_q_status,
    input  tgr_pkg::t_back_status        i_back_status,
    output logic                         o_push,
    output tgr_pkg::t_desc               o_desc,
    output logic                         o_font_we,
    output logic [tgr_pkg::FONT_AW-1:0]  o_font_waddr,
    output logic [7:0]                   o_font_wdata
);

    logic [9:0] r_col;
    logic [7:0] r_row;
    logic [9:0] n_col;
    logic [7:0] n_row;

    logic       accept;
    logic       print;
    logic [7:0] code_eff;
    logic       newline;
    logic [8:0] last_row;
    logic       wrap;
    logic [8:0] next_row;
    logic       scroll;
    logic [7:0] row_new;
    logic [9:0] col_wr;
    logic       load_blocked;

    assign load_blocked = !(i_q_status.empty && i_back_status.idle);
    assign o_stall = i_q_status.full || ((i_cmd == tgr_pkg::CMD_LOAD) && load_blocked);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        code_eff = i_char_code[7] ? tgr_pkg::CODE_QUESTION : i_char_code;
        newline  = (code_eff == tgr_pkg::CODE_NEWLINE);
        if (i_text_rows == 9'd0) begin
            last_row = 9'd0;
        end else if (i_text_rows > 9'd256) begin
            last_row = 9'd255;
        end else begin
            last_row = i_text_rows - 9'd1;
        end
        wrap     = newline || (r_col >= i_text_columns);
        next_row = wrap ? ({1'b0, r_row} + 9'd1) : {1'b0, r_row};
        scroll   = (next_row > last_row);
        row_new  = scroll ? last_row[7:0] : next_row[7:0];
        col_wr   = wrap ? 10'd0 : r_col;
    end

    assign print  = accept && (i_cmd == tgr_pkg::CMD_PRINT)
                    && (i_char_code != tgr_pkg::CODE_NULL);
    assign o_push = print && (scroll || !newline);

    always_comb begin
        o_desc.scroll = scroll;
        o_desc.glyph  = !newline;
        o_desc.code   = code_eff;
        o_desc.column = col_wr;
        o_desc.row    = row_new;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (print) begin
            n_row = row_new;
            n_col = newline ? col_wr : (col_wr + 10'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_font_we    = accept && (i_cmd == tgr_pkg::CMD_LOAD);
    assign o_font_waddr = tgr_pkg::FONT_AW'(i_font_address);
    assign o_font_wdata = i_font_byte;

endmodule

/* hdl/tgr_back.sv */
// back: expands queued print work into scroll and glyph row words
module tgr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [12:0]                  i_screen_width,
    input  tgr_pkg::t_desc               i_desc,
    input  tgr_pkg::t_q_status           i_q_status,
    output logic                         o_pop,
    output tgr_pkg::t_back_status        o_status,
    output logic [tgr_pkg::FONT_AW-1:0]  o_font_raddr,
    input  logic [7:0]                   i_font_rdata,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_kind,
    output logic [tgr_pkg::PIX_W-1:0]    o_pixel_index,
    output logic [7:0]                   o_row_bits,
    output logic                         o_last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SETUP  = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_GLYPH  = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    tgr_pkg::t_desc                r_desc;
    logic [tgr_pkg::PIX_W-1:0]     r_pix;
    logic [tgr_pkg::PIX_W-1:0]     n_pix;
    logic [tgr_pkg::GROW_W-1:0]    r_j;
    logic [tgr_pkg::GROW_W-1:0]    n_j;

    logic                          r_s1_valid;
    logic                          r_s1_kind;
    logic                          r_s1_last;
    logic [tgr_pkg::PIX_W-1:0]     r_s1_pix;
    logic [tgr_pkg::FONT_AW-1:0]   r_s1_addr;

    logic                          r_out_valid;
    logic                          r_out_kind;
    logic                          r_out_last;
    logic [tgr_pkg::PIX_W-1:0]     r_out_pix;
    logic [7:0]                    r_out_bits;

    logic                          advance;
    logic                          s1_ready;
    logic                          s1_load;
    logic                          s1_kind;
    logic                          s1_last;
    logic [tgr_pkg::PIX_W-1:0]     s1_pix;
    logic [tgr_pkg::LINE_W-1:0]    line0;
    logic [tgr_pkg::PIX_W-1:0]     base;
    logic [tgr_pkg::GADDR_W-1:0]   gaddr;
    logic [tgr_pkg::FONT_AW-1:0]   s1_addr;
    logic                          last_j;

    assign advance  = !r_out_valid || !i_stall;
    assign s1_ready = !r_s1_valid || advance;
    assign last_j   = (r_j == tgr_pkg::GROW_W'(tgr_pkg::GLYPH_HEIGHT - 1));

    assign line0 = tgr_pkg::LINE_W'(r_desc.row) * tgr_pkg::LINE_W'(tgr_pkg::GLYPH_HEIGHT);
    assign base  = tgr_pkg::PIX_W'({r_desc.column, 3'b000})
                   + tgr_pkg::PIX_W'(tgr_pkg::PIX_W'(line0)
                                     * tgr_pkg::PIX_W'(i_screen_width));
    assign gaddr = tgr_pkg::GADDR_W'(r_desc.code)
                   * tgr_pkg::GADDR_W'(tgr_pkg::GLYPH_HEIGHT)
                   + tgr_pkg::GADDR_W'(r_j);
    assign s1_addr = tgr_pkg::FONT_AW'(gaddr);

    always_comb begin
        n_state = r_state;
        n_pix   = r_pix;
        n_j     = r_j;
        o_pop   = 1'b0;
        s1_load = 1'b0;
        s1_kind = tgr_pkg::KIND_GLYPH;
        s1_last = 1'b0;
        s1_pix  = r_pix;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_pix   = base;
                n_j     = '0;
                n_state = r_desc.scroll ? S_SCROLL : S_GLYPH;
            end
            S_SCROLL: begin
                if (s1_ready) begin
                    s1_load = 1'b1;
                    s1_kind = tgr_pkg::KIND_SCROLL;
                    s1_last = !r_desc.glyph;
                    s1_pix  = '0;
                    n_state = r_desc.glyph ? S_GLYPH : S_IDLE;
                end
            end
            S_GLYPH: begin
                if (s1_ready) begin
                    s1_load = 1'b1;
                    s1_last = last_j;
                    n_pix   = r_pix + tgr_pkg::PIX_W'(i_screen_width);
                    n_j     = r_j + 1'b1;
                    if (last_j) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // re-read the held address while the output stalls
    assign o_font_raddr = s1_load ? s1_addr : r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s1_ready) begin
                r_s1_valid <= s1_load;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
        r_j   <= n_j;
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (s1_load) begin
            r_s1_kind <= s1_kind;
            r_s1_last <= s1_last;
            r_s1_pix  <= s1_pix;
            r_s1_addr <= s1_addr;
        end
        if (advance && r_s1_valid) begin
            r_out_kind <= r_s1_kind;
            r_out_last <= r_s1_last;
            r_out_pix  <= r_s1_pix;
            r_out_bits <= (r_s1_kind == tgr_pkg::KIND_SCROLL) ? 8'd0 : i_font_rdata;
        end
    end

    assign o_status.idle = (r_state == S_IDLE) && !r_s1_valid;

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_pixel_index = r_out_pix;
    assign o_row_bits    = r_out_bits;
    assign o_last        = r_out_last;

endmodule

/* hdl/text_console_glyph_renderer_top.sv */
// top level: text console glyph renderer with config registers and font store
// A print word leaves the queue in the idle state, passes a setup state, gives a
// scroll word if the cursor leaves the last row and then, unless it is a newline,
// one word per glyph row (16), as the back end reads one font byte per cycle,
// while the output does not stall, from the single read port of the font store.
// Font loads are held off until all earlier prints have read their glyphs. Code 0
// and a newline that does not scroll give no word. Up to four queued prints let
// the input side run ahead.
module text_console_glyph_renderer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [12:0]                i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [7:0]                 i_char_code,
    input  logic [10:0]                i_font_address,
    input  logic [7:0]                 i_font_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_kind,
    output logic [tgr_pkg::PIX_W-1:0]  o_pixel_index,
    output logic [7:0]                 o_row_bits,
    output logic                       o_last
);

    logic [12:0] r_screen_width;
    logic [9:0]  r_text_columns;
    logic [8:0]  r_text_rows;

    tgr_pkg::t_q_status            q_status;
    tgr_pkg::t_back_status         back_status;
    tgr_pkg::t_desc                push_desc;
    tgr_pkg::t_desc                head_desc;
    logic                          push;
    logic                          pop;
    logic                          font_we;
    logic [tgr_pkg::FONT_AW-1:0]   font_waddr;
    logic [7:0]                    font_wdata;
    logic [tgr_pkg::FONT_AW-1:0]   font_raddr;
    logic [7:0]                    font_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= tgr_pkg::RST_SCREEN_WIDTH;
            r_text_columns <= tgr_pkg::RST_TEXT_COLUMNS;
            r_text_rows    <= tgr_pkg::RST_TEXT_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tgr_pkg::CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data;
                tgr_pkg::CFG_TEXT_COLUMNS: r_text_columns <= i_cfg_data[9:0];
                tgr_pkg::CFG_TEXT_ROWS:    r_text_rows    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    tgr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_font_address (i_font_address),
        .i_font_byte    (i_font_byte),
        .i_text_columns (r_text_columns),
        .i_text_rows    (r_text_rows),
        .i_q_status     (q_status),
        .i_back_status  (back_status),
        .o_push         (push),
        .o_desc         (push_desc),
        .o_font_we      (font_we),
        .o_font_waddr   (font_waddr),
        .o_font_wdata   (font_wdata)
    );

    tgr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_desc   (head_desc),
        .o_status (q_status)
    );

    tgr_ram #(
        .WIDTH (8),
        .DEPTH (tgr_pkg::FONT_STORE_BYTES)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (font_waddr),
        .i_wdata (font_wdata),
        .i_raddr (font_raddr),
        .o_rdata (font_rdata)
    );

    tgr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_screen_width (r_screen_width),
        .i_desc         (head_desc),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_status       (back_status),
        .o_font_raddr   (font_raddr),
        .i_font_rdata   (font_rdata),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_kind         (o_kind),
        .o_pixel_index  (o_pixel_index),
        .o_row_bits     (o_row_bits),
        .o_last         (o_last)
    );

`ifndef SYNTHESIS
    a_scroll_word_blank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == tgr_pkg::KIND_SCROLL)
        |-> (o_pixel_index == '0) && (o_row_bits == 8'd0))
        else $error("scroll word carries pixel data");

    a_load_only_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        font_we |-> q_status.empty && back_status.idle && !push)
        else $error("font written while glyph reads pending");

    a_no_queue_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("descriptor queue overflow");

    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("descriptor queue underflow");
`endif

endmodule
